### hdl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg - shared types and codes of the I2C bit-level master
// Command codes, sequencer phase codes, reset values and the state record.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam logic [2:0] MODE_TICK  = 3'd0;
   localparam logic [2:0] MODE_START = 3'd1;
   localparam logic [2:0] MODE_STOP  = 3'd2;
   localparam logic [2:0] MODE_WRITE = 3'd3;
   localparam logic [2:0] MODE_WACK  = 3'd4;
   localparam logic [2:0] MODE_READ  = 3'd5;
   localparam logic [2:0] MODE_SACK  = 3'd6;

   localparam logic [4:0] PH_IDLE    = 5'd0;
   localparam logic [4:0] PH_SA_A    = 5'd1;
   localparam logic [4:0] PH_SA_B    = 5'd2;
   localparam logic [4:0] PH_SA_C    = 5'd3;
   localparam logic [4:0] PH_ST_A    = 5'd4;
   localparam logic [4:0] PH_ST_B    = 5'd5;
   localparam logic [4:0] PH_ST_END  = 5'd6;
   localparam logic [4:0] PH_SB_DATA = 5'd7;
   localparam logic [4:0] PH_SB_HIGH = 5'd8;
   localparam logic [4:0] PH_SB_LOW  = 5'd9;
   localparam logic [4:0] PH_SB_END  = 5'd10;
   localparam logic [4:0] PH_WA_REL  = 5'd11;
   localparam logic [4:0] PH_WA_HIGH = 5'd12;
   localparam logic [4:0] PH_WA_POLL = 5'd13;
   localparam logic [4:0] PH_RB_LOW  = 5'd14;
   localparam logic [4:0] PH_RB_HIGH = 5'd15;
   localparam logic [4:0] PH_AK_A    = 5'd16;
   localparam logic [4:0] PH_AK_B    = 5'd17;
   localparam logic [4:0] PH_AK_C    = 5'd18;

   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
   localparam logic [2:0] DLY_LONG  = 3'd3;
   localparam logic [2:0] DLY_DATA  = 3'd1;
   localparam logic [2:0] DLY_NONE  = 3'd0;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic [4:0] phase;
      logic [2:0] delay_count;
      logic [3:0] bit_count;
      logic [7:0] shift_reg;
      logic [7:0] poll_count;
      logic       scl;
      logic       sda;
      logic       sda_oe;
      logic       error_flag;
      logic [7:0] rx_byte;
      logic       ack_latch;
   } seq_state_type;

   localparam seq_state_type SEQ_STATE_RESET = '{
      phase:       PH_IDLE,
      delay_count: 3'd0,
      bit_count:   4'd0,
      shift_reg:   8'd0,
      poll_count:  8'd0,
      scl:         1'b1,
      sda:         1'b1,
      sda_oe:      1'b1,
      error_flag:  1'b0,
      rx_byte:     8'd0,
      ack_latch:   1'b0
   };

endpackage

### hdl/i2cm_step.sv
// ----------------------------------------------------------------------------
// i2cm_step - one-tick sequencer step
// Takes the current sequencer state and one tick item, gives the next state
// and the end-of-sequence flag.
// ----------------------------------------------------------------------------
module i2cm_step import i2cm_pkg::*; (
   input  seq_state_type cur_state,
   input  logic [2:0]    mode,
   input  logic [7:0]    write_byte,
   input  logic          ack_bit,
   input  logic          sda_in,
   input  logic [7:0]    ack_timeout,
   output seq_state_type nxt_state,
   output logic          seq_done
);

   seq_state_type s;
   logic          done;

   always_comb begin
      s    = cur_state;
      done = 1'b0;

      // launch a command only from idle
      if (s.phase == PH_IDLE && mode >= MODE_START && mode <= MODE_SACK) begin
         s.delay_count = DLY_NONE;
         s.bit_count   = 4'd0;
         s.ack_latch   = ack_bit;
         case (mode)
            MODE_START: s.phase = PH_SA_A;
            MODE_STOP:  s.phase = PH_ST_A;
            MODE_WRITE: begin
               s.phase     = PH_SB_DATA;
               s.shift_reg = write_byte;
            end
            MODE_WACK: begin
               s.phase      = PH_WA_REL;
               s.poll_count = 8'd0;
            end
            MODE_READ: begin
               s.phase     = PH_RB_LOW;
               s.shift_reg = 8'd0;
            end
            default:    s.phase = PH_AK_A;
         endcase
      end

      if (s.phase != PH_IDLE) begin
         if (s.delay_count != DLY_NONE) begin
            s.delay_count = s.delay_count - 3'd1;
         end else begin
            unique case (s.phase)
               PH_SA_A: begin
                  s.sda_oe = 1'b1; s.sda = 1'b1; s.scl = 1'b1;
                  s.delay_count = DLY_LONG; s.phase = PH_SA_B;
               end
               PH_SA_B: begin
                  s.sda = 1'b0; s.delay_count = DLY_LONG; s.phase = PH_SA_C;
               end
               PH_SA_C: begin
                  s.scl = 1'b0; s.phase = PH_IDLE; done = 1'b1;
               end
               PH_ST_A: begin
                  s.sda_oe = 1'b1; s.scl = 1'b0; s.sda = 1'b0;
                  s.delay_count = DLY_LONG; s.phase = PH_ST_B;
               end
               PH_ST_B: begin
                  s.scl = 1'b1; s.sda = 1'b1;
                  s.delay_count = DLY_LONG; s.phase = PH_ST_END;
               end
               PH_ST_END: begin
                  s.phase = PH_IDLE; done = 1'b1;
               end
               PH_SB_DATA: begin
                  s.sda_oe = 1'b1; s.scl = 1'b0;
                  s.sda = s.shift_reg[7];
                  s.shift_reg = {s.shift_reg[6:0], 1'b0};
                  s.delay_count = DLY_DATA; s.phase = PH_SB_HIGH;
               end
               PH_SB_HIGH: begin
                  s.scl = 1'b1; s.delay_count = DLY_DATA; s.phase = PH_SB_LOW;
               end
               PH_SB_LOW: begin
                  s.scl = 1'b0; s.delay_count = DLY_DATA;
                  s.bit_count = s.bit_count + 4'd1;
                  s.phase = (s.bit_count >= BITS_PER_BYTE) ? PH_SB_END : PH_SB_DATA;
               end
               PH_SB_END: begin
                  s.phase = PH_IDLE; done = 1'b1;
               end
               PH_WA_REL: begin
                  s.sda_oe = 1'b0; s.sda = 1'b1;
                  s.delay_count = DLY_NONE; s.phase = PH_WA_HIGH;
               end
               PH_WA_HIGH: begin
                  s.scl = 1'b1; s.delay_count = DLY_NONE; s.phase = PH_WA_POLL;
               end
               PH_WA_POLL: begin
                  if (!sda_in) begin
                     s.scl = 1'b0; s.error_flag = 1'b0;
                     s.phase = PH_IDLE; done = 1'b1;
                  end else begin
                     s.poll_count = s.poll_count + 8'd1;
                     // timed out: flag it and fall into a stop
                     if (s.poll_count > ack_timeout) begin
                        s.error_flag = 1'b1;
                        s.sda_oe = 1'b1; s.scl = 1'b0; s.sda = 1'b0;
                        s.delay_count = DLY_LONG; s.phase = PH_ST_B;
                     end
                  end
               end
               PH_RB_LOW: begin
                  s.sda_oe = 1'b0; s.scl = 1'b0;
                  s.delay_count = DLY_DATA; s.phase = PH_RB_HIGH;
               end
               PH_RB_HIGH: begin
                  s.scl = 1'b1;
                  s.shift_reg = {s.shift_reg[6:0], sda_in};
                  s.delay_count = DLY_NONE;
                  s.bit_count = s.bit_count + 4'd1;
                  if (s.bit_count >= BITS_PER_BYTE) begin
                     s.rx_byte = s.shift_reg;
                     s.phase = PH_AK_A;
                  end else begin
                     s.phase = PH_RB_LOW;
                  end
               end
               PH_AK_A: begin
                  s.scl = 1'b0; s.sda_oe = 1'b1; s.sda = ~s.ack_latch;
                  s.delay_count = DLY_DATA; s.phase = PH_AK_B;
               end
               PH_AK_B: begin
                  s.scl = 1'b1; s.delay_count = DLY_DATA; s.phase = PH_AK_C;
               end
               PH_AK_C: begin
                  s.scl = 1'b0; s.phase = PH_IDLE; done = 1'b1;
               end
               default: s.phase = PH_IDLE;
            endcase
         end
      end
   end

   assign nxt_state = s;
   assign seq_done  = done;

endmodule

### hdl/i2c_bit_level_master.sv
// ----------------------------------------------------------------------------
// i2c_bit_level_master - I2C master, bit-level sequencer on microsecond ticks
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  mode, write_byte, ack_bit, sda_in
//   rsp_     out        rsp_valid/rsp_stall  scl, sda, drive, busy, done, data, err
//   csr_     in         csr_wr_en            ack_timeout (8 bit)
//
// One tick item per cycle unless req_stall holds input back: the sequencer step is a single
// combinational pass from the state registers to the result register.
// Reset is synchronous: idle sequencer, SCL and SDA driven high, timeout of 250.
// req_stall rises only while a result is held by rsp_stall (and during reset).
// ----------------------------------------------------------------------------
module i2c_bit_level_master import i2cm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_write_byte,
   input  logic       req_ack_bit,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic       rsp_sda_drive,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_read_data,
   output logic       rsp_ack_error,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   seq_state_type state_ff, state_in;
   logic          done_in;
   logic [7:0]    ack_timeout_ff;
   logic          rsp_valid_ff;
   logic          scl_ff, sda_ff, drive_ff, busy_ff, done_ff, err_ff;
   logic [7:0]    data_ff;
   logic          req_take;

   assign req_stall = reset | (rsp_valid_ff & rsp_stall);
   assign req_take  = req_valid & ~req_stall;

   i2cm_step u_step (
      .cur_state   (state_ff),
      .mode        (req_mode),
      .write_byte  (req_write_byte),
      .ack_bit     (req_ack_bit),
      .sda_in      (req_sda_in),
      .ack_timeout (ack_timeout_ff),
      .nxt_state   (state_in),
      .seq_done    (done_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SEQ_STATE_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ack_timeout_ff <= csr_wr_data;
         end
         if (req_take) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, loaded with each accepted tick
   always_ff @(posedge clock) begin
      if (req_take) begin
         scl_ff   <= state_in.scl;
         sda_ff   <= state_in.sda;
         drive_ff <= state_in.sda_oe;
         busy_ff  <= (state_in.phase != PH_IDLE);
         done_ff  <= done_in;
         data_ff  <= state_in.rx_byte;
         err_ff   <= state_in.error_flag;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_level = scl_ff;
   assign rsp_sda_level = sda_ff;
   assign rsp_sda_drive = drive_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;
   assign rsp_read_data = data_ff;
   assign rsp_ack_error = err_ff;

endmodule

### hdl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker - port-level checks of the I2C bit-level master
// Watches the handshakes and result fields, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker import i2cm_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_scl_level,
   input logic       rsp_sda_level,
   input logic       rsp_sda_drive,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_read_data,
   input logic       rsp_ack_error
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a held result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_read_data) && $stable(rsp_scl_level)
         && $stable(rsp_sda_level) && $stable(rsp_sda_drive) && $stable(rsp_busy_res)
         && $stable(rsp_done_res) && $stable(rsp_ack_error))
      else $error("result payload changed while stalled");

   // every accepted tick yields a result next cycle
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item gave no result");

   // input is held back only by a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   // a finished sequence leaves the sequencer idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while busy");

endmodule

bind i2c_bit_level_master i2cm_checker u_i2cm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_scl_level (rsp_scl_level),
   .rsp_sda_level (rsp_sda_level),
   .rsp_sda_drive (rsp_sda_drive),
   .rsp_busy_res  (rsp_busy_res),
   .rsp_done_res  (rsp_done_res),
   .rsp_read_data (rsp_read_data),
   .rsp_ack_error (rsp_ack_error)
);

### dv/tb_i2c_bit_level_master.sv
// ----------------------------------------------------------------------------
// tb_i2c_bit_level_master - tick-level check of the I2C bit-level master
// Feeds one tick item per cycle via a valid/stall driver, save for random gaps
// and stalls outside the calm burst. A cycle model of the sequencer forecasts
// every result line; a monitor compares each result field by field. Directed
// commands come first, then random transfers under several acknowledge timeouts.
// ----------------------------------------------------------------------------
module tb_i2c_bit_level_master;
   import i2cm_pkg::*;

   localparam logic [2:0] MODE_UNUSED      = 3'd7;
   localparam logic [7:0] TIMEOUT_AT_RESET = 8'd250;
   localparam logic [2:0] HOLD_BUS         = 3'd3;
   localparam logic [2:0] HOLD_BIT         = 3'd1;
   localparam logic [2:0] HOLD_NONE        = 3'd0;
   localparam logic [3:0] BYTE_BITS        = 4'd8;
   localparam int         POLL_GUARD       = 260;
   localparam int         BURST_TICKS      = 80;

   typedef enum logic [4:0] {
      SEQ_IDLE, START_HI, START_SDA, START_SCL, STOP_BEGIN, STOP_RISE, STOP_HOLD,
      BIT_DATA, BIT_HIGH, BIT_LOW, BYTE_END, ACK_RELEASE, ACK_RISE, ACK_POLL,
      RD_LOW, RD_HIGH, ANS_DRIVE, ANS_HIGH, ANS_END
   } seq_phase_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] wbyte;
      logic       ack;
      logic       sda_in;
   } tick_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       drive;
      logic       busy;
      logic       done;
      logic [7:0] rdata;
      logic       err;
   } bus_line_type;

   typedef struct {
      seq_phase_type ph;
      logic [2:0]    dly;
      logic [3:0]    nbits;
      logic [7:0]    shifter;
      logic [7:0]    polls;
      logic          scl;
      logic          sda;
      logic          oe;
      logic          err;
      logic [7:0]    rx;
      logic          ack_hold;
      logic [7:0]    timeout;
   } master_model_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_mode = MODE_TICK;
   logic [7:0] req_write_byte = 8'd0;
   logic       req_ack_bit = 1'b0;
   logic       req_sda_in = 1'b1;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_scl_level;
   logic       rsp_sda_level;
   logic       rsp_sda_drive;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [7:0] rsp_read_data;
   logic       rsp_ack_error;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;

   tick_type         tick_queue[$];
   bus_line_type     predicted_lines[$];
   master_model_type plan;
   master_model_type chk;
   tick_type         nxt;
   tick_type         seen;
   bus_line_type     want;
   bus_line_type     got;
   bit               req_taken = 1'b0;
   bit               calm = 1'b0;
   int               ticks_sent = 0;
   int               mismatch_count = 0;

   i2c_bit_level_master dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_write_byte (req_write_byte),
      .req_ack_bit    (req_ack_bit),
      .req_sda_in     (req_sda_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_level  (rsp_sda_level),
      .rsp_sda_drive  (rsp_sda_drive),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_read_data  (rsp_read_data),
      .rsp_ack_error  (rsp_ack_error),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic master_model_type idle_model();
      master_model_type m;
      m.ph       = SEQ_IDLE;
      m.dly      = HOLD_NONE;
      m.nbits    = 4'd0;
      m.shifter  = 8'd0;
      m.polls    = 8'd0;
      m.scl      = 1'b1;
      m.sda      = 1'b1;
      m.oe       = 1'b1;
      m.err      = 1'b0;
      m.rx       = 8'd0;
      m.ack_hold = 1'b0;
      m.timeout  = TIMEOUT_AT_RESET;
      return m;
   endfunction

   function automatic void enter_stop(inout master_model_type m);
      m.oe  = 1'b1;
      m.scl = 1'b0;
      m.sda = 1'b0;
      m.dly = HOLD_BUS;
      m.ph  = STOP_RISE;
   endfunction

   // Advance the sequencer by one tick and return the bus line after it.
   function automatic void master_step(inout master_model_type m, input tick_type t,
                                       output bus_line_type r);
      logic done;
      done = 1'b0;
      if (m.ph == SEQ_IDLE && t.mode >= MODE_START && t.mode <= MODE_SACK) begin
         m.dly      = HOLD_NONE;
         m.nbits    = 4'd0;
         m.ack_hold = t.ack;
         case (t.mode)
            MODE_START: m.ph = START_HI;
            MODE_STOP:  m.ph = STOP_BEGIN;
            MODE_WRITE: begin
               m.ph = BIT_DATA;
               m.shifter = t.wbyte;
            end
            MODE_WACK: begin
               m.ph = ACK_RELEASE;
               m.polls = 8'd0;
            end
            MODE_READ: begin
               m.ph = RD_LOW;
               m.shifter = 8'd0;
            end
            default: m.ph = ANS_DRIVE;
         endcase
      end
      if (m.ph != SEQ_IDLE) begin
         if (m.dly != HOLD_NONE) begin
            m.dly = m.dly - 3'd1;
         end else begin
            case (m.ph)
               START_HI: begin
                  m.oe = 1'b1; m.sda = 1'b1; m.scl = 1'b1;
                  m.dly = HOLD_BUS; m.ph = START_SDA;
               end
               START_SDA: begin
                  m.sda = 1'b0; m.dly = HOLD_BUS; m.ph = START_SCL;
               end
               START_SCL: begin
                  m.scl = 1'b0; m.ph = SEQ_IDLE; done = 1'b1;
               end
               STOP_BEGIN: enter_stop(m);
               STOP_RISE: begin
                  m.scl = 1'b1; m.sda = 1'b1; m.dly = HOLD_BUS; m.ph = STOP_HOLD;
               end
               STOP_HOLD: begin
                  m.ph = SEQ_IDLE; done = 1'b1;
               end
               BIT_DATA: begin
                  m.oe = 1'b1; m.scl = 1'b0; m.sda = m.shifter[7];
                  m.shifter = {m.shifter[6:0], 1'b0};
                  m.dly = HOLD_BIT; m.ph = BIT_HIGH;
               end
               BIT_HIGH: begin
                  m.scl = 1'b1; m.dly = HOLD_BIT; m.ph = BIT_LOW;
               end
               BIT_LOW: begin
                  m.scl = 1'b0; m.dly = HOLD_BIT;
                  m.nbits = m.nbits + 4'd1;
                  m.ph = (m.nbits >= BYTE_BITS) ? BYTE_END : BIT_DATA;
               end
               BYTE_END: begin
                  m.ph = SEQ_IDLE; done = 1'b1;
               end
               ACK_RELEASE: begin
                  m.oe = 1'b0; m.sda = 1'b1; m.dly = HOLD_NONE; m.ph = ACK_RISE;
               end
               ACK_RISE: begin
                  m.scl = 1'b1; m.dly = HOLD_NONE; m.ph = ACK_POLL;
               end
               ACK_POLL: begin
                  if (!t.sda_in) begin
                     m.scl = 1'b0; m.err = 1'b0; m.ph = SEQ_IDLE; done = 1'b1;
                  end else begin
                     // the 8-bit counter wraps, so a timeout of 255 never fires
                     m.polls = m.polls + 8'd1;
                     if (m.polls > m.timeout) begin
                        m.err = 1'b1;
                        enter_stop(m);
                     end
                  end
               end
               RD_LOW: begin
                  m.oe = 1'b0; m.scl = 1'b0; m.dly = HOLD_BIT; m.ph = RD_HIGH;
               end
               RD_HIGH: begin
                  m.scl = 1'b1;
                  m.shifter = {m.shifter[6:0], t.sda_in};
                  m.dly = HOLD_NONE;
                  m.nbits = m.nbits + 4'd1;
                  if (m.nbits >= BYTE_BITS) begin
                     m.rx = m.shifter;
                     m.ph = ANS_DRIVE;
                  end else begin
                     m.ph = RD_LOW;
                  end
               end
               ANS_DRIVE: begin
                  m.scl = 1'b0; m.oe = 1'b1; m.sda = !m.ack_hold;
                  m.dly = HOLD_BIT; m.ph = ANS_HIGH;
               end
               ANS_HIGH: begin
                  m.scl = 1'b1; m.dly = HOLD_BIT; m.ph = ANS_END;
               end
               ANS_END: begin
                  m.scl = 1'b0; m.ph = SEQ_IDLE; done = 1'b1;
               end
               default: m.ph = SEQ_IDLE;
            endcase
         end
      end
      r = '{m.scl, m.sda, m.oe, m.ph != SEQ_IDLE, done, m.rx, m.err};
   endfunction

   task automatic report_mismatch(input string what, input int actual, input int wanted);
      if (mismatch_count < 40) begin
         $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, actual, wanted);
      end
      mismatch_count++;
   endtask

   // Queue one tick and step the planning copy so the stimulus knows the phase.
   task automatic push_tick(input logic [2:0] mode, input logic [7:0] wb,
                            input logic ack, input logic sda);
      tick_type t;
      bus_line_type unused;
      t = '{mode, wb, ack, sda};
      tick_queue.push_back(t);
      master_step(plan, t, unused);
      ticks_sent++;
   endtask

   // low_pct: share of ticks with SDA pulled low; noise commands land while busy.
   task automatic finish_seq(input int low_pct);
      int guard;
      logic [2:0] md;
      guard = 0;
      while (plan.ph != SEQ_IDLE) begin
         guard++;
         md = ($urandom_range(11) == 0) ? 3'($urandom_range(7)) : MODE_TICK;
         push_tick(md, 8'($urandom), 1'($urandom),
                   (guard > POLL_GUARD || $urandom_range(99) < low_pct) ? 1'b0 : 1'b1);
      end
   endtask

   task automatic run_cmd(input logic [2:0] mode, input logic [7:0] wb, input logic ack,
                          input int low_pct);
      push_tick(mode, wb, ack, ($urandom_range(99) < low_pct) ? 1'b0 : 1'b1);
      finish_seq(low_pct);
   endtask

   function automatic int pick_ack_pct();
      return ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 5);
   endfunction

   task automatic random_transfer();
      int nbytes;
      bit rd;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(4, 1)) begin
            run_cmd(3'($urandom_range(7)), 8'($urandom), 1'($urandom), $urandom_range(100));
         end
         return;
      end
      run_cmd(MODE_START, 8'($urandom), 1'($urandom), 50);
      run_cmd(MODE_WRITE, 8'($urandom), 1'($urandom), 50);
      run_cmd(MODE_WACK, 8'($urandom), 1'($urandom), pick_ack_pct());
      rd = 1'($urandom);
      nbytes = $urandom_range(2, 1);
      for (int i = 0; i < nbytes; i++) begin
         if (rd) begin
            // ACK all but the last byte
            run_cmd(MODE_READ, 8'($urandom), i != nbytes - 1, 50);
         end else begin
            run_cmd(MODE_WRITE, 8'($urandom), 1'($urandom), 50);
            run_cmd(MODE_WACK, 8'($urandom), 1'($urandom), pick_ack_pct());
         end
      end
      if ($urandom_range(4) != 0) begin
         run_cmd(MODE_STOP, 8'($urandom), 1'($urandom), 50);
      end
      repeat ($urandom_range(2)) push_tick(MODE_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
   endtask

   task automatic random_burst();
      int start;
      start = ticks_sent;
      while (ticks_sent - start < BURST_TICKS) random_transfer();
   endtask

   task automatic drain();
      while (tick_queue.size() != 0 || req_valid || predicted_lines.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Write the timeout only with the bus idle and nothing in flight.
   task automatic set_timeout(input logic [7:0] value);
      drain();
      @(negedge clock);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      plan.timeout = value;
      chk.timeout  = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (tick_queue.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
            nxt = tick_queue.pop_front();
            req_mode       <= nxt.mode;
            req_write_byte <= nxt.wbyte;
            req_ack_bit    <= nxt.ack;
            req_sda_in     <= nxt.sda_in;
            req_valid      <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !calm && ($urandom_range(99) < 6);
   end

   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         seen = '{req_mode, req_write_byte, req_ack_bit, req_sda_in};
         master_step(chk, seen, want);
         predicted_lines.push_back(want);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_scl_level, rsp_sda_level, rsp_sda_drive, rsp_busy_res,
                 rsp_done_res, rsp_read_data, rsp_ack_error};
         if (predicted_lines.size() == 0) begin
            report_mismatch("result with no tick pending", 1, 0);
         end else begin
            want = predicted_lines.pop_front();
            if (got.scl !== want.scl)     report_mismatch("scl_level", got.scl, want.scl);
            if (got.sda !== want.sda)     report_mismatch("sda_level", got.sda, want.sda);
            if (got.drive !== want.drive) report_mismatch("sda_drive", got.drive, want.drive);
            if (got.busy !== want.busy)   report_mismatch("busy_res", got.busy, want.busy);
            if (got.done !== want.done)   report_mismatch("done_res", got.done, want.done);
            if (got.rdata !== want.rdata) report_mismatch("read_data", got.rdata, want.rdata);
            if (got.err !== want.err)     report_mismatch("ack_error", got.err, want.err);
         end
      end
   end

   initial begin
      plan = idle_model();
      chk  = idle_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed commands at the reset timeout
      push_tick(MODE_TICK, 8'h00, 1'b0, 1'b1);
      push_tick(MODE_UNUSED, 8'hFF, 1'b1, 1'b0);
      run_cmd(MODE_START, 8'h00, 1'b0, 50);
      push_tick(MODE_START, 8'h00, 1'b0, 1'b1);
      push_tick(MODE_READ, 8'hA5, 1'b1, 1'b0);
      finish_seq(50);
      run_cmd(MODE_WRITE, 8'hA5, 1'b1, 50);
      run_cmd(MODE_WACK, 8'h00, 1'b0, 100);
      run_cmd(MODE_READ, 8'h00, 1'b1, 50);
      run_cmd(MODE_SACK, 8'h00, 1'b1, 50);
      run_cmd(MODE_SACK, 8'h00, 1'b0, 50);
      run_cmd(MODE_STOP, 8'h00, 1'b0, 50);

      set_timeout(8'd0);
      run_cmd(MODE_WACK, 8'h00, 1'b0, 0);

      set_timeout(8'd1);
      calm = 1'b1;
      random_burst();
      drain();
      calm = 1'b0;

      set_timeout(8'($urandom_range(20, 2)));
      random_burst();

      // hold SDA high past the counter wrap, then acknowledge
      set_timeout(8'd255);
      run_cmd(MODE_WACK, 8'h00, 1'b0, 0);

      drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #(8 * 200000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

### i2c_bit_level_master.f
hdl/i2cm_pkg.sv
hdl/i2cm_step.sv
hdl/i2c_bit_level_master.sv
hdl/i2cm_checker.sv
dv/tb_i2c_bit_level_master.sv
